FILE: hdl/hil4_pkg.sv
// Shared types and constants for the 4-D Gray-code curve index encoder/decoder.
package hil4_pkg;

    localparam int LEVEL_BITS_DEF = 16;   // curve levels, one coordinate bit each
    localparam int NUM_AXES       = 4;
    localparam int COORD_W        = 16;
    localparam int INDEX_W        = 64;
    localparam int TDATA_W        = 128;  // four coordinates plus one index
    localparam int TUSER_W        = 1;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } hil4_cmd_t;

    // Work item travelling down the level pipeline.
    // Encode: coord holds the source, idx collects nibbles.
    // Decode: idx holds the source, coord collects bits.
    typedef struct packed {
        hil4_cmd_t                           cmd;
        logic [NUM_AXES-1:0][COORD_W-1:0]    coord;
        logic [INDEX_W-1:0]                  idx;
        logic [NUM_AXES-1:0][1:0]            perm;
        logic [NUM_AXES-1:0]                 flip;
    } hil4_item_t;

endpackage

FILE: hdl/hil4_level.sv
// One curve level: gather/scatter through the rotation, Gray step, rotation update.
module hil4_level #(
    parameter int LVL = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  hil4_pkg::hil4_item_t in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output hil4_pkg::hil4_item_t out_item
);

    localparam int NIB_LSB = 4 * LVL;

    logic                 valid_reg;
    hil4_pkg::hil4_item_t item_reg;
    hil4_pkg::hil4_item_t item_next;

    logic [3:0] b_enc;
    logic [3:0] g_enc;
    logic [3:0] g_dec;
    logic [3:0] b_dec;
    logic [3:0] g_sel;
    logic [1:0] hi_axis;
    logic [1:0] first_axis;

    always_comb begin
        item_next = in_item;

        // encode path: gather one bit per axis through perm
        for (int d = 0; d < hil4_pkg::NUM_AXES; d++) begin
            b_enc[d] = in_item.coord[in_item.perm[d]][LVL];
        end
        g_enc = (b_enc ^ in_item.flip) ^ ((b_enc ^ in_item.flip) >> 1);

        // decode path: Gray-decode the stored nibble
        g_dec    = in_item.idx[NIB_LSB +: 4];
        b_dec[3] = g_dec[3];
        b_dec[2] = g_dec[2] ^ g_dec[3];
        b_dec[1] = g_dec[1] ^ g_dec[2] ^ g_dec[3];
        b_dec[0] = g_dec[0] ^ g_dec[1] ^ g_dec[2] ^ g_dec[3];
        b_dec    = b_dec ^ in_item.flip;

        if (in_item.cmd == hil4_pkg::CMD_DECODE) begin
            g_sel = g_dec;
            for (int j = 0; j < hil4_pkg::NUM_AXES; j++) begin
                for (int d = 0; d < hil4_pkg::NUM_AXES; d++) begin
                    if (b_dec[d] && (in_item.perm[d] == 2'(j))) begin
                        item_next.coord[j][LVL] = 1'b1;
                    end
                end
            end
        end else begin
            g_sel = g_enc;
            item_next.idx[NIB_LSB +: 4] = g_enc;
        end

        // rotation update (nibble not 0 or F): swap axis 0 with highest set bit, toggle flip
        if (g_sel[3]) begin
            hi_axis = 2'd3;
        end else if (g_sel[2]) begin
            hi_axis = 2'd2;
        end else if (g_sel[1]) begin
            hi_axis = 2'd1;
        end else begin
            hi_axis = 2'd0;
        end
        first_axis = in_item.perm[0];
        if ((g_sel != 4'h0) && (g_sel != 4'hF)) begin
            item_next.perm[0]       = in_item.perm[hi_axis];
            item_next.perm[hi_axis] = first_axis;
            item_next.flip          = in_item.flip ^ (4'b0001 << first_axis);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: hdl/hil4_out.sv
// Output register: selects the fields of the chosen direction and zeroes the rest.
module hil4_out (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  hil4_pkg::hil4_item_t               in_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [hil4_pkg::TDATA_W-1:0]       out_data
);

    logic                         valid_reg;
    logic [hil4_pkg::TDATA_W-1:0] data_reg;
    logic [hil4_pkg::TDATA_W-1:0] data_next;

    always_comb begin
        if (in_item.cmd == hil4_pkg::CMD_DECODE) begin
            data_next = {in_item.coord, {hil4_pkg::INDEX_W{1'b0}}};
        end else begin
            data_next = {{(hil4_pkg::NUM_AXES * hil4_pkg::COORD_W){1'b0}}, in_item.idx};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hdl/hilbert4d_encode_decode.sv
// Top level of the 4-D Gray-code curve index encoder/decoder pipeline.
//
//  channel | dir | tdata (low bit up)                          | tuser
//  --------+-----+---------------------------------------------+--------------
//  s_      | in  | coord_x, coord_y, coord_z, coord_m, index_in | command
//  m_      | out | index_out, out_x, out_y, out_z, out_m        | -
//
// One pipeline stage per curve level (LEVEL_BITS of them, top level first)
// plus one output register; one transfer per cycle while m_tready is high.
// Each stage has its own valid bit; ready ripples back stage by stage, so empty
// stages fill while the output is stalled and nothing is dropped or repeated.
// aresetn (synchronous) clears the valid bits only; payload is not reset.
module hilbert4d_encode_decode #(
    parameter int LEVEL_BITS = hil4_pkg::LEVEL_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] coord_x, [31:16] coord_y, [47:32] coord_z, [63:48] coord_m,
    // [127:64] index_in
    input  logic [hil4_pkg::TDATA_W-1:0]  s_tdata,
    // [0] command (0 encode, 1 decode)
    input  logic [hil4_pkg::TUSER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [63:0] index_out, [79:64] out_x, [95:80] out_y, [111:96] out_z,
    // [127:112] out_m
    output logic [hil4_pkg::TDATA_W-1:0]  m_tdata
);

    localparam int CW = hil4_pkg::NUM_AXES * hil4_pkg::COORD_W;

    // stage k consumes item_q[k] and produces item_q[k+1]
    hil4_pkg::hil4_item_t item_q [LEVEL_BITS+1];
    logic                 vld    [LEVEL_BITS+1];
    logic                 rdy    [LEVEL_BITS+1];
    hil4_pkg::hil4_cmd_t  s_cmd;

    assign s_cmd = hil4_pkg::hil4_cmd_t'(s_tuser[0]);

    // Entry item: rotation at identity, no flips; destination fields cleared.
    always_comb begin
        item_q[0].cmd  = s_cmd;
        item_q[0].perm = {2'd3, 2'd2, 2'd1, 2'd0};
        item_q[0].flip = 4'h0;
        if (s_cmd == hil4_pkg::CMD_DECODE) begin
            item_q[0].coord = '0;
            item_q[0].idx   = s_tdata[CW +: hil4_pkg::INDEX_W];
        end else begin
            item_q[0].coord = s_tdata[CW-1:0];
            item_q[0].idx   = '0;
        end
    end

    assign vld[0]   = s_tvalid;
    assign s_tready = rdy[0];

    // Level pipeline, top coordinate bit first.
    for (genvar k = 0; k < LEVEL_BITS; k++) begin : g_level
        hil4_level #(
            .LVL (LEVEL_BITS - 1 - k)
        ) u_level (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[k]),
            .in_ready  (rdy[k]),
            .in_item   (item_q[k]),
            .out_valid (vld[k+1]),
            .out_ready (rdy[k+1]),
            .out_item  (item_q[k+1])
        );
    end

    // Output register holds the finished transfer.
    hil4_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld[LEVEL_BITS]),
        .in_ready  (rdy[LEVEL_BITS]),
        .in_item   (item_q[LEVEL_BITS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

`ifndef SYNTH
    // A result carries either an index or coordinates, never both.
    a_one_direction: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[hil4_pkg::INDEX_W-1:0] == '0) ||
                      (m_tdata[hil4_pkg::TDATA_W-1:hil4_pkg::INDEX_W] == '0)))
        else $error("result carries both index and coordinates");

    // An empty output register means the whole ready chain is open.
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register empty");

    // A transfer leaving the last level always lands in the output register.
    a_last_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld[LEVEL_BITS] && rdy[LEVEL_BITS]) |=> m_tvalid)
        else $error("item lost between last level and output");
`endif

endmodule
